### rtl/gpib_handshake_engine_assert.svh
// ----------------------------------------------------------------------------
// gpib handshake engine assertion macros
// concurrent assertion wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef GPIB_HANDSHAKE_ENGINE_ASSERT_SVH
`define GPIB_HANDSHAKE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// plain property check
`define GHE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gpib handshake engine assertion failed");
// same-cycle implication
`define GHE_ASSERT_IMP(name, ante, cons) \
  `GHE_ASSERT(name, (ante) |-> (cons))
// next-cycle implication
`define GHE_ASSERT_NEXT(name, ante, cons) \
  `GHE_ASSERT(name, (ante) |=> (cons))
`else
`define GHE_ASSERT(name, prop)
`define GHE_ASSERT_IMP(name, ante, cons)
`define GHE_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### rtl/ghe_pkg.sv
// ----------------------------------------------------------------------------
// ghe_pkg
// shared types and constants of the gpib three-wire handshake engine
// ----------------------------------------------------------------------------
`default_nettype none

package ghe_pkg;

  localparam int unsigned WaitW = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0] Eos7Mask = 8'h7f;
  localparam logic [7:0] ByteOnes = 8'hff;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SEND = 2'd1,
    OP_RECV = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_SENT     = 2'd1,
    ST_RECEIVED = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE_LISTEN = 3'd0,
    PH_TX_PRESENCE = 3'd1,
    PH_TX_READY    = 3'd2,
    PH_TX_SETTLE   = 3'd3,
    PH_TX_ACCEPT   = 3'd4,
    PH_RX_VALID    = 3'd5,
    PH_RX_RELEASE  = 3'd6,
    PH_IDLE_TALK   = 3'd7
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EOS_CHAR      = 3'd0,
    CFG_EOS_ENABLE    = 3'd1,
    CFG_EOS_EIGHT_BIT = 3'd2,
    CFG_TIMEOUT_TICKS = 3'd3,
    CFG_SETTLE_TICKS  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  eos_char;
    logic        eos_enable;
    logic        eos_eight_bit;
    logic [15:0] timeout_ticks;
    logic [7:0]  settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] send_byte;
    logic       send_eoi_now;
    logic       send_command;
    logic       send_first;
    logic       line_dav;
    logic       line_nrfd;
    logic       line_ndac;
    logic       line_eoi;
    logic [7:0] line_data;
  } item_t;

  typedef struct packed {
    logic       assert_dav;
    logic       assert_nrfd;
    logic       assert_ndac;
    logic       assert_eoi;
    logic       assert_atn;
    logic [7:0] drive_data;
    logic       talk_mode;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       rx_end;
    logic       rx_eos;
    logic [1:0] status;
  } res_t;

endpackage

`default_nettype wire

### rtl/ghe_cfg.sv
// ----------------------------------------------------------------------------
// ghe_cfg
// configuration register file of the handshake engine
// ----------------------------------------------------------------------------
`default_nettype none

module ghe_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [ghe_pkg::CfgIdxW-1:0]   wr_index_i,
  input  wire logic [ghe_pkg::CfgDataW-1:0]  wr_data_i,
  output ghe_pkg::cfg_t                      cfg_o
);

  ghe_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        ghe_pkg::CFG_EOS_CHAR:      cfg_d.eos_char      = wr_data_i[7:0];
        ghe_pkg::CFG_EOS_ENABLE:    cfg_d.eos_enable    = wr_data_i[0];
        ghe_pkg::CFG_EOS_EIGHT_BIT: cfg_d.eos_eight_bit = wr_data_i[0];
        ghe_pkg::CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = wr_data_i[15:0];
        ghe_pkg::CFG_SETTLE_TICKS:  cfg_d.settle_ticks  = wr_data_i[7:0];
        default: ;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eos_char      <= 8'd0;
      cfg_q.eos_enable    <= 1'b0;
      cfg_q.eos_eight_bit <= 1'b0;
      cfg_q.timeout_ticks <= 16'd1000;
      cfg_q.settle_ticks  <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/ghe_fsm.sv
// ----------------------------------------------------------------------------
// ghe_fsm
// handshake state machine: one step per item, result from the new state
// ----------------------------------------------------------------------------
`default_nettype none
`include "gpib_handshake_engine_assert.svh"

module ghe_fsm (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   step_i,
  input  wire ghe_pkg::item_t item_i,
  input  wire ghe_pkg::cfg_t  cfg_i,
  output ghe_pkg::res_t  res_o
);

  ghe_pkg::phase_e phase_q, phase_d;
  logic [ghe_pkg::WaitW-1:0] wait_q, wait_d;
  logic [7:0] settle_q, settle_d;
  logic [7:0] tx_data_q, tx_data_d;
  logic       tx_eoi_q, tx_eoi_d;
  logic       tx_atn_q, tx_atn_d;
  logic [7:0] rx_data_q, rx_data_d;
  logic       rx_eoi_q, rx_eoi_d;

  logic       idle;
  logic       got;
  ghe_pkg::status_e status;
  logic [ghe_pkg::WaitW-1:0] lim_one, lim_ten, lim_sel;
  logic       wait_out;
  logic [ghe_pkg::WaitW-1:0] wait_inc;

  assign idle = (phase_q == ghe_pkg::PH_IDLE_LISTEN) || (phase_q == ghe_pkg::PH_IDLE_TALK);

  // nrfd wait of the source runs ten times the limit
  assign lim_one  = {{(ghe_pkg::WaitW-16){1'b0}}, cfg_i.timeout_ticks};
  assign lim_ten  = (lim_one << 3) + (lim_one << 1);
  assign lim_sel  = (phase_q == ghe_pkg::PH_TX_READY) ? lim_ten : lim_one;
  assign wait_out = (wait_q >= lim_sel);
  assign wait_inc = wait_q + 1'b1;

  // next state
  always_comb begin
    phase_d   = phase_q;
    wait_d    = wait_q;
    settle_d  = settle_q;
    tx_data_d = tx_data_q;
    tx_eoi_d  = tx_eoi_q;
    tx_atn_d  = tx_atn_q;
    rx_data_d = rx_data_q;
    rx_eoi_d  = rx_eoi_q;
    status    = ghe_pkg::ST_NONE;
    got       = 1'b0;
    if (step_i) begin
      unique case (item_i.op)
        ghe_pkg::OP_SEND: begin
          if (idle) begin
            tx_data_d = item_i.send_byte;
            tx_eoi_d  = item_i.send_eoi_now;
            tx_atn_d  = item_i.send_command;
            phase_d   = item_i.send_first ? ghe_pkg::PH_TX_PRESENCE : ghe_pkg::PH_TX_READY;
            wait_d    = '0;
          end
        end
        ghe_pkg::OP_RECV: begin
          if (idle) begin
            phase_d = ghe_pkg::PH_RX_VALID;
            wait_d  = '0;
          end
        end
        ghe_pkg::OP_TICK: begin
          unique case (phase_q)
            ghe_pkg::PH_TX_PRESENCE: begin
              if (item_i.line_nrfd && !item_i.line_ndac) begin
                wait_d  = '0;
                phase_d = ghe_pkg::PH_TX_READY;
              end else if (wait_out) begin
                wait_d  = '0;
                phase_d = ghe_pkg::PH_IDLE_TALK;
                status  = ghe_pkg::ST_TIMEOUT;
              end else begin
                wait_d = wait_inc;
              end
            end
            ghe_pkg::PH_TX_READY: begin
              if (item_i.line_nrfd) begin
                wait_d   = '0;
                settle_d = cfg_i.settle_ticks;
                phase_d  = ghe_pkg::PH_TX_SETTLE;
              end else if (wait_out) begin
                wait_d  = '0;
                phase_d = ghe_pkg::PH_IDLE_TALK;
                status  = ghe_pkg::ST_TIMEOUT;
              end else begin
                wait_d = wait_inc;
              end
            end
            ghe_pkg::PH_TX_SETTLE: begin
              if (settle_q == 8'd0) begin
                phase_d = ghe_pkg::PH_TX_ACCEPT;
              end else begin
                settle_d = settle_q - 8'd1;
              end
            end
            ghe_pkg::PH_TX_ACCEPT: begin
              if (item_i.line_ndac) begin
                wait_d  = '0;
                phase_d = ghe_pkg::PH_IDLE_TALK;
                status  = ghe_pkg::ST_SENT;
              end else if (wait_out) begin
                wait_d  = '0;
                phase_d = ghe_pkg::PH_IDLE_TALK;
                status  = ghe_pkg::ST_TIMEOUT;
              end else begin
                wait_d = wait_inc;
              end
            end
            ghe_pkg::PH_RX_VALID: begin
              if (!item_i.line_dav) begin
                wait_d    = '0;
                rx_data_d = ~item_i.line_data;
                rx_eoi_d  = ~item_i.line_eoi;
                phase_d   = ghe_pkg::PH_RX_RELEASE;
              end else if (wait_out) begin
                wait_d  = '0;
                phase_d = ghe_pkg::PH_IDLE_LISTEN;
                status  = ghe_pkg::ST_TIMEOUT;
              end else begin
                wait_d = wait_inc;
              end
            end
            ghe_pkg::PH_RX_RELEASE: begin
              if (item_i.line_dav) begin
                wait_d  = '0;
                phase_d = ghe_pkg::PH_IDLE_LISTEN;
                status  = ghe_pkg::ST_RECEIVED;
                got     = 1'b1;
              end else if (wait_out) begin
                wait_d  = '0;
                phase_d = ghe_pkg::PH_IDLE_LISTEN;
                status  = ghe_pkg::ST_TIMEOUT;
              end else begin
                wait_d = wait_inc;
              end
            end
            ghe_pkg::PH_IDLE_LISTEN,
            ghe_pkg::PH_IDLE_TALK: ;
          endcase
        end
        default: ;  // undefined op, ignored
      endcase
    end
  end

  // outputs, from the state after the step
  logic       sending;
  logic [7:0] eos_mask;

  always_comb begin
    sending  = (phase_d == ghe_pkg::PH_TX_PRESENCE) || (phase_d == ghe_pkg::PH_TX_READY) ||
               (phase_d == ghe_pkg::PH_TX_SETTLE) || (phase_d == ghe_pkg::PH_TX_ACCEPT);
    eos_mask = cfg_i.eos_eight_bit ? ghe_pkg::ByteOnes : ghe_pkg::Eos7Mask;

    res_o.assert_dav  = (phase_d == ghe_pkg::PH_TX_ACCEPT);
    res_o.assert_nrfd = (phase_d == ghe_pkg::PH_IDLE_LISTEN) ||
                        (phase_d == ghe_pkg::PH_RX_RELEASE);
    res_o.assert_ndac = (phase_d == ghe_pkg::PH_IDLE_LISTEN) ||
                        (phase_d == ghe_pkg::PH_RX_VALID);
    res_o.assert_eoi  = sending && (phase_d != ghe_pkg::PH_TX_PRESENCE) && tx_eoi_d;
    res_o.assert_atn  = sending && tx_atn_d;
    res_o.drive_data  = ((phase_d == ghe_pkg::PH_TX_SETTLE) ||
                         (phase_d == ghe_pkg::PH_TX_ACCEPT)) ? ~tx_data_d : ghe_pkg::ByteOnes;
    res_o.talk_mode   = sending || (phase_d == ghe_pkg::PH_IDLE_TALK);
    res_o.busy_res    = (phase_d != ghe_pkg::PH_IDLE_LISTEN) &&
                        (phase_d != ghe_pkg::PH_IDLE_TALK);
    res_o.rx_byte     = got ? rx_data_d : 8'd0;
    res_o.rx_end      = got && rx_eoi_d;
    res_o.rx_eos      = got && cfg_i.eos_enable &&
                        ((rx_data_d & eos_mask) == (cfg_i.eos_char & eos_mask));
    res_o.status      = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ghe_pkg::PH_IDLE_LISTEN;
      wait_q    <= '0;
      settle_q  <= 8'd0;
      tx_data_q <= 8'd0;
      tx_eoi_q  <= 1'b0;
      tx_atn_q  <= 1'b0;
      rx_data_q <= 8'd0;
      rx_eoi_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      wait_q    <= wait_d;
      settle_q  <= settle_d;
      tx_data_q <= tx_data_d;
      tx_eoi_q  <= tx_eoi_d;
      tx_atn_q  <= tx_atn_d;
      rx_data_q <= rx_data_d;
      rx_eoi_q  <= rx_eoi_d;
    end
  end

  // every exit from a wait clears the counter
  `GHE_ASSERT_IMP(a_idle_wait_clear, idle, wait_q == '0)
  // a received byte only comes out of the dav release wait
  `GHE_ASSERT_IMP(a_rx_from_release, step_i && (status == ghe_pkg::ST_RECEIVED),
                  phase_q == ghe_pkg::PH_RX_RELEASE)
  // ndac released while dav is held ends the send in talk idle
  `GHE_ASSERT_NEXT(a_accept_done,
                   step_i && (item_i.op == ghe_pkg::OP_TICK) &&
                   (phase_q == ghe_pkg::PH_TX_ACCEPT) && item_i.line_ndac,
                   phase_q == ghe_pkg::PH_IDLE_TALK)

endmodule

`default_nettype wire

### rtl/gpib_handshake_engine.sv
// ----------------------------------------------------------------------------
// gpib_handshake_engine
// ieee-488 three-wire handshake engine, top level
// ----------------------------------------------------------------------------
// usage:
//   - input channel (in_valid_i / in_stall_o) carries one item: a tick with
//     the sampled bus lines, a send request or a receive request
//   - output channel (out_valid_o / out_stall_i) returns exactly one result
//     per item: line drive levels, direction, busy and the step's status
//   - configuration channel (cfg_valid_i / cfg_ready_o) writes eos and
//     timing registers; write only while the engine is quiet
//   - each item is held in the input register, then the state machine step
//     writes its result into the result register
//   - throughput is one item per cycle while the receiver does not stall, set
//     by the single state machine step between the input and result registers
//   - when the receiver stalls, the held result and the held input item
//     stay put and in_stall_o rises; items resume as soon as stall drops
//   - reset puts the engine idle in listen direction (nrfd and ndac
//     asserted), eos off, timeout 1000 ticks, settle 1 tick
// ----------------------------------------------------------------------------
`default_nettype none
`include "gpib_handshake_engine_assert.svh"

module gpib_handshake_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // item channel
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [1:0]                   op_i,
  input  wire logic [7:0]                   send_byte_i,
  input  wire logic                         send_eoi_now_i,
  input  wire logic                         send_command_i,
  input  wire logic                         send_first_i,
  input  wire logic                         line_dav_i,
  input  wire logic                         line_nrfd_i,
  input  wire logic                         line_ndac_i,
  input  wire logic                         line_eoi_i,
  input  wire logic [7:0]                   line_data_i,
  // result channel
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic                         assert_dav_o,
  output      logic                         assert_nrfd_o,
  output      logic                         assert_ndac_o,
  output      logic                         assert_eoi_o,
  output      logic                         assert_atn_o,
  output      logic [7:0]                   drive_data_o,
  output      logic                         talk_mode_o,
  output      logic                         busy_res_o,
  output      logic [7:0]                   rx_byte_o,
  output      logic                         rx_end_o,
  output      logic                         rx_eos_o,
  output      logic [1:0]                   status_o,
  // configuration write channel
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [ghe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ghe_pkg::CfgDataW-1:0] cfg_data_i
);

  ghe_pkg::cfg_t  cfg;
  ghe_pkg::item_t item_q, item_d;
  ghe_pkg::res_t  res_q, res_d;
  logic in_vld_q, in_vld_d;
  logic out_vld_q, out_vld_d;
  logic in_take;
  logic step;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  ghe_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the held item steps the state machine once the result slot is free
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.op           = op_i;
    item_d.send_byte    = send_byte_i;
    item_d.send_eoi_now = send_eoi_now_i;
    item_d.send_command = send_command_i;
    item_d.send_first   = send_first_i;
    item_d.line_dav     = line_dav_i;
    item_d.line_nrfd    = line_nrfd_i;
    item_d.line_ndac    = line_ndac_i;
    item_d.line_eoi     = line_eoi_i;
    item_d.line_data    = line_data_i;
  end

  ghe_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_comb begin
    priority if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
    out_vld_d = step || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign assert_dav_o  = res_q.assert_dav;
  assign assert_nrfd_o = res_q.assert_nrfd;
  assign assert_ndac_o = res_q.assert_ndac;
  assign assert_eoi_o  = res_q.assert_eoi;
  assign assert_atn_o  = res_q.assert_atn;
  assign drive_data_o  = res_q.drive_data;
  assign talk_mode_o   = res_q.talk_mode;
  assign busy_res_o    = res_q.busy_res;
  assign rx_byte_o     = res_q.rx_byte;
  assign rx_end_o      = res_q.rx_end;
  assign rx_eos_o      = res_q.rx_eos;
  assign status_o      = res_q.status;

  // a held item with a free result slot never stalls the sender
  `GHE_ASSERT_IMP(a_no_false_stall, in_vld_q && !out_vld_q, !in_stall_o)
  // a result that is not taken survives to the next cycle
  `GHE_ASSERT_NEXT(a_result_held, out_vld_q && out_stall_i, out_vld_q)
  // a stepped item leaves a result behind
  `GHE_ASSERT_NEXT(a_step_result, step, out_vld_q)

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gpib three-wire handshake engine: requests go
// in over the valid/stall channel, a step model of the engine predicts
// each step's line drive and status, and every result is compared field by
// field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ghe_pkg::*;

  localparam int unsigned ResetCycles    = 11;
  localparam int unsigned MaxGap         = 10;
  localparam int unsigned LongHold       = 80;
  localparam int unsigned DrainCycles    = 6;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned ReadyWaitScale = 10;
  // write to an index past the register file, must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  // op code with no meaning, must be ignored like a busy request
  localparam logic [1:0] OpUndef = 2'd3;

  // --------------------------------------------------------------------------
  // step model and result checker
  // --------------------------------------------------------------------------
  class handshake_tracker;
    cfg_t             regs;
    phase_e           phase;
    logic [WaitW-1:0] wait_cnt;
    logic [7:0]       settle_cnt;
    logic [7:0]       tx_held;
    logic             tx_eoi;
    logic             tx_atn;
    logic [7:0]       rx_held;
    logic             rx_end_held;
    res_t             expected[$];
    int               errors;

    function new();
      regs.eos_char      = 8'h00;
      regs.eos_enable    = 1'b0;
      regs.eos_eight_bit = 1'b0;
      regs.timeout_ticks = 16'd1000;
      regs.settle_ticks  = 8'd1;
      phase       = PH_IDLE_LISTEN;
      wait_cnt    = '0;
      settle_cnt  = '0;
      tx_held     = '0;
      tx_eoi      = 1'b0;
      tx_atn      = 1'b0;
      rx_held     = '0;
      rx_end_held = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_EOS_CHAR:      regs.eos_char      = value[7:0];
        CFG_EOS_ENABLE:    regs.eos_enable    = value[0];
        CFG_EOS_EIGHT_BIT: regs.eos_eight_bit = value[0];
        CFG_TIMEOUT_TICKS: regs.timeout_ticks = value;
        CFG_SETTLE_TICKS:  regs.settle_ticks  = value[7:0];
        default: ;
      endcase
    endfunction

    // true once the wait has used up its limit, else counts one more tick
    function bit ran_out(logic [WaitW-1:0] limit);
      if (wait_cnt >= limit) return 1'b1;
      wait_cnt = wait_cnt + 1'b1;
      return 1'b0;
    endfunction

    function void note_item(item_t it);
      res_t             r;
      status_e          st;
      logic             got;
      logic             idle;
      logic             sending;
      logic             driving;
      logic [7:0]       mask;
      logic [WaitW-1:0] ready_lim;
      got       = 1'b0;
      st        = ST_NONE;
      idle      = (phase == PH_IDLE_LISTEN) || (phase == PH_IDLE_TALK);
      ready_lim = WaitW'(regs.timeout_ticks) * WaitW'(ReadyWaitScale);
      if (it.op == OP_SEND && idle) begin
        tx_held  = it.send_byte;
        tx_eoi   = it.send_eoi_now;
        tx_atn   = it.send_command;
        phase    = it.send_first ? PH_TX_PRESENCE : PH_TX_READY;
        wait_cnt = '0;
      end else if (it.op == OP_RECV && idle) begin
        phase    = PH_RX_VALID;
        wait_cnt = '0;
      end else if (it.op == OP_TICK) begin
        case (phase)
          PH_TX_PRESENCE: begin
            if (it.line_nrfd && !it.line_ndac) begin
              wait_cnt = '0;
              phase    = PH_TX_READY;
            end else if (ran_out(WaitW'(regs.timeout_ticks))) begin
              wait_cnt = '0;
              phase    = PH_IDLE_TALK;
              st       = ST_TIMEOUT;
            end
          end
          PH_TX_READY: begin
            if (it.line_nrfd) begin
              wait_cnt   = '0;
              settle_cnt = regs.settle_ticks;
              phase      = PH_TX_SETTLE;
            end else if (ran_out(ready_lim)) begin
              wait_cnt = '0;
              phase    = PH_IDLE_TALK;
              st       = ST_TIMEOUT;
            end
          end
          PH_TX_SETTLE: begin
            if (settle_cnt == 8'd0) phase = PH_TX_ACCEPT;
            else settle_cnt = settle_cnt - 1'b1;
          end
          PH_TX_ACCEPT: begin
            if (it.line_ndac) begin
              wait_cnt = '0;
              phase    = PH_IDLE_TALK;
              st       = ST_SENT;
            end else if (ran_out(WaitW'(regs.timeout_ticks))) begin
              wait_cnt = '0;
              phase    = PH_IDLE_TALK;
              st       = ST_TIMEOUT;
            end
          end
          PH_RX_VALID: begin
            if (!it.line_dav) begin
              wait_cnt    = '0;
              rx_held     = ~it.line_data;
              rx_end_held = ~it.line_eoi;
              phase       = PH_RX_RELEASE;
            end else if (ran_out(WaitW'(regs.timeout_ticks))) begin
              wait_cnt = '0;
              phase    = PH_IDLE_LISTEN;
              st       = ST_TIMEOUT;
            end
          end
          PH_RX_RELEASE: begin
            if (it.line_dav) begin
              wait_cnt = '0;
              phase    = PH_IDLE_LISTEN;
              st       = ST_RECEIVED;
              got      = 1'b1;
            end else if (ran_out(WaitW'(regs.timeout_ticks))) begin
              wait_cnt = '0;
              phase    = PH_IDLE_LISTEN;
              st       = ST_TIMEOUT;
            end
          end
          default: ;
        endcase
      end

      mask    = regs.eos_eight_bit ? ByteOnes : Eos7Mask;
      sending = phase inside {PH_TX_PRESENCE, PH_TX_READY, PH_TX_SETTLE, PH_TX_ACCEPT};
      driving = phase inside {PH_TX_SETTLE, PH_TX_ACCEPT};
      r.assert_dav  = (phase == PH_TX_ACCEPT);
      r.assert_nrfd = (phase == PH_IDLE_LISTEN) || (phase == PH_RX_RELEASE);
      r.assert_ndac = (phase == PH_IDLE_LISTEN) || (phase == PH_RX_VALID);
      r.assert_eoi  = sending && (phase != PH_TX_PRESENCE) && tx_eoi;
      r.assert_atn  = sending && tx_atn;
      r.drive_data  = driving ? ~tx_held : ByteOnes;
      r.talk_mode   = sending || (phase == PH_IDLE_TALK);
      r.busy_res    = sending || (phase == PH_RX_VALID) || (phase == PH_RX_RELEASE);
      r.rx_byte     = got ? rx_held : 8'h00;
      r.rx_end      = got && rx_end_held;
      r.rx_eos      = got && regs.eos_enable &&
                      ((rx_held & mask) == (regs.eos_char & mask));
      r.status      = st;
      expected.push_back(r);
    endfunction

    function void same(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(res_t seen);
      res_t want;
      if (expected.size() == 0) begin
        $error("result arrived with nothing expected");
        errors++;
        return;
      end
      want = expected.pop_front();
      same("assert_dav", 8'(want.assert_dav), 8'(seen.assert_dav));
      same("assert_nrfd", 8'(want.assert_nrfd), 8'(seen.assert_nrfd));
      same("assert_ndac", 8'(want.assert_ndac), 8'(seen.assert_ndac));
      same("assert_eoi", 8'(want.assert_eoi), 8'(seen.assert_eoi));
      same("assert_atn", 8'(want.assert_atn), 8'(seen.assert_atn));
      same("drive_data", want.drive_data, seen.drive_data);
      same("talk_mode", 8'(want.talk_mode), 8'(seen.talk_mode));
      same("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
      same("rx_byte", want.rx_byte, seen.rx_byte);
      same("rx_end", 8'(want.rx_end), 8'(seen.rx_end));
      same("rx_eos", 8'(want.rx_eos), 8'(seen.rx_eos));
      same("status", 8'(want.status), 8'(seen.status));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and dut wiring
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  // request channel
  logic  in_valid;
  logic  in_stall;
  item_t cur_item;

  // result channel
  logic       out_valid;
  logic       out_stall;
  logic       assert_dav;
  logic       assert_nrfd;
  logic       assert_ndac;
  logic       assert_eoi;
  logic       assert_atn;
  logic [7:0] drive_data;
  logic       talk_mode;
  logic       busy_res;
  logic [7:0] rx_byte;
  logic       rx_end;
  logic       rx_eos;
  logic [1:0] status;

  // register write channel
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // idling controls of the sender and the receiver
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;
  int rx_gap;
  int unsigned cycle_cnt;

  handshake_tracker sb = new();

  always #4 clk_i = ~clk_i;

  gpib_handshake_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (cur_item.op),
    .send_byte_i    (cur_item.send_byte),
    .send_eoi_now_i (cur_item.send_eoi_now),
    .send_command_i (cur_item.send_command),
    .send_first_i   (cur_item.send_first),
    .line_dav_i     (cur_item.line_dav),
    .line_nrfd_i    (cur_item.line_nrfd),
    .line_ndac_i    (cur_item.line_ndac),
    .line_eoi_i     (cur_item.line_eoi),
    .line_data_i    (cur_item.line_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .assert_dav_o   (assert_dav),
    .assert_nrfd_o  (assert_nrfd),
    .assert_ndac_o  (assert_ndac),
    .assert_eoi_o   (assert_eoi),
    .assert_atn_o   (assert_atn),
    .drive_data_o   (drive_data),
    .talk_mode_o    (talk_mode),
    .busy_res_o     (busy_res),
    .rx_byte_o      (rx_byte),
    .rx_end_o       (rx_end),
    .rx_eos_o       (rx_eos),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // watchdog: a hung handshake or a lost result ends here
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: everything is sampled on the rising edge, drivers move on the
  // falling edge, so no check depends on event order within a step
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // every accepted request advances the model by one step
      if (in_valid && !in_stall) sb.note_item(cur_item);
      if (out_valid && !out_stall) begin
        sb.check_result({assert_dav, assert_nrfd, assert_ndac, assert_eoi, assert_atn,
                         drive_data, talk_mode, busy_res, rx_byte, rx_end, rx_eos,
                         status});
        // the receiver draws its next wait per result
        rx_gap = rx_idle_on ? int'($urandom_range(0, MaxGap)) : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall per result, plus one long hold-off counted here so
  // the engine backs up and stalls its request side
  // --------------------------------------------------------------------------
  initial begin
    int hold_cnt;
    hold_cnt  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LongHold;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // entered and left on a falling edge; valid stays high into the next
  // request when no gap is drawn
  task automatic push_item(input item_t it);
    int gap;
    gap = tx_idle_on ? int'($urandom_range(0, MaxGap)) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_item = it;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender pause: nothing outstanding, then enough cycles for the pipe
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (sb.expected.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // unused upper data bits carry noise, the engine must mask them
  task automatic set_regs(input logic [7:0] eos, input logic en, input logic eight,
                          input logic [15:0] tmo, input logic [7:0] settle);
    cfg_put(CFG_EOS_CHAR, {8'($urandom), eos});
    cfg_put(CFG_EOS_ENABLE, {15'($urandom), en});
    cfg_put(CFG_EOS_EIGHT_BIT, {15'($urandom), eight});
    cfg_put(CFG_TIMEOUT_TICKS, tmo);
    cfg_put(CFG_SETTLE_TICKS, {8'($urandom), settle});
  endtask

  function automatic item_t bus_item(input logic [1:0] op, input logic [7:0] b,
                                     input logic eoi_now, input logic cmd,
                                     input logic first, input logic dav,
                                     input logic nrfd, input logic ndac,
                                     input logic eoi, input logic [7:0] data);
    item_t it;
    it.op           = op;
    it.send_byte    = b;
    it.send_eoi_now = eoi_now;
    it.send_command = cmd;
    it.send_first   = first;
    it.line_dav     = dav;
    it.line_nrfd    = nrfd;
    it.line_ndac    = ndac;
    it.line_eoi     = eoi;
    it.line_data    = data;
    return it;
  endfunction

  // mostly the request that moves the current handshake on, with random
  // content; the rest is raw noise (busy requests, undefined op, bad lines)
  function automatic item_t make_item();
    item_t       it;
    logic [31:0] raw;
    int          pick;
    raw  = $urandom;
    it   = raw[$bits(item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 12) return it;
    pick = $urandom_range(0, 9);
    it.op = OP_TICK;
    case (sb.phase)
      PH_IDLE_LISTEN, PH_IDLE_TALK: begin
        if (pick < 4) it.op = OP_SEND;
        else if (pick < 8) it.op = OP_RECV;
      end
      PH_TX_PRESENCE: begin
        if (pick < 8) begin
          it.line_nrfd = 1'b1;
          it.line_ndac = 1'b0;
        end
      end
      PH_TX_READY:  if (pick < 8) it.line_nrfd = 1'b1;
      PH_TX_ACCEPT: if (pick < 7) it.line_ndac = 1'b1;
      PH_RX_VALID: begin
        if (pick < 7) it.line_dav = 1'b0;
        // land on the eos character, or on it with bit 7 flipped
        if ($urandom_range(0, 9) < 4)
          it.line_data = ~(sb.regs.eos_char ^ {1'($urandom), 7'd0});
      end
      PH_RX_RELEASE: if (pick < 7) it.line_dav = 1'b1;
      default: ;
    endcase
    return it;
  endfunction

  task automatic run_phase(input int n, input bit tx_idle, input bit rx_idle,
                           input bit squeeze);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    for (int k = 0; k < n; k++) begin
      push_item(make_item());
      // long receiver hold-off while requests keep coming back to back
      if (squeeze && k == n / 3) hold_req = 1'b1;
      // sender pause until everything outstanding has come back
      if (squeeze && k == (2 * n) / 3) wait_quiet();
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    item_t directed[$];
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    cur_item   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 1'b0;
    rx_gap     = 0;
    cycle_cnt  = 0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at reset settings: timeout 1000, settle 1, eos off
    // tick while idle, then an undefined op
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 0, 0, 0, 0, 8'h00));
    directed.push_back(bus_item(OpUndef, 8'hff, 1, 1, 1, 1, 1, 1, 1, 8'hff));
    // command byte with eoi and presence check, plus a send while busy
    directed.push_back(bus_item(OP_SEND, 8'h00, 1, 1, 1, 1, 1, 1, 1, 8'hff));
    directed.push_back(bus_item(OP_SEND, 8'hff, 0, 0, 0, 1, 1, 1, 1, 8'h00));
    // no listener yet, then listener present
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 0, 1, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 0, 1, 8'h00));
    // nrfd released, settle, dav asserted, ndac still held, then released
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 0, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 0, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 0, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 0, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 1, 1, 8'h00));
    // tick while idle in talk direction
    directed.push_back(bus_item(OP_TICK, 8'hff, 1, 1, 1, 0, 0, 0, 0, 8'hff));
    // plain data byte 0xff, no presence check
    directed.push_back(bus_item(OP_SEND, 8'hff, 0, 0, 0, 1, 1, 1, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 0, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 0, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 0, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 1, 1, 8'h00));
    // receive with eoi, a receive while busy, all-zero lines give 0xff
    directed.push_back(bus_item(OP_RECV, 8'h00, 0, 0, 0, 1, 1, 1, 1, 8'h00));
    directed.push_back(bus_item(OP_RECV, 8'h00, 0, 0, 0, 1, 1, 1, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 0, 1, 1, 0, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 1, 1, 0, 8'h00));
    // receive without eoi, all-one lines give 0x00
    directed.push_back(bus_item(OP_RECV, 8'h00, 0, 0, 0, 1, 1, 1, 1, 8'h00));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 0, 0, 0, 1, 8'hff));
    directed.push_back(bus_item(OP_TICK, 8'h00, 0, 0, 0, 1, 0, 0, 1, 8'hff));
    foreach (directed[i]) push_item(directed[i]);
    wait_quiet();

    // eight-bit eos, short timeouts, no settle delay
    cfg_put(CfgUnused, CfgDataW'($urandom));
    set_regs(8'($urandom), 1'b1, 1'b1, 16'd2, 8'd0);
    run_phase(130, 1'b1, 1'b1, 1'b0);
    wait_quiet();

    // seven-bit eos, zero timeout, back-to-back traffic with a long hold-off
    set_regs(8'($urandom), 1'b1, 1'b0, 16'd0, 8'($urandom_range(1, 3)));
    run_phase(130, 1'b0, 1'b0, 1'b1);
    wait_quiet();

    // all-ones eos character, timeout of one tick, sender gaps only
    set_regs(8'hff, 1'b1, 1'b0, 16'd1, 8'd1);
    run_phase(130, 1'b1, 1'b0, 1'b0);
    wait_quiet();

    // extremes: longest timeout and settle, eos off
    set_regs(8'h00, 1'b0, 1'b1, 16'hffff, 8'hff);
    run_phase(160, 1'b0, 1'b1, 1'b0);
    wait_quiet();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
